// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker; all but ASSERT_ALWAYS take an active-low reset.
// Depends on nothing; each macro takes a label, clock and two terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while reset is released.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked while reset is released.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/tsdg_pkg.sv =====
// Package for the two-axis step/direction generator: field widths, codes,
// register indexes, reset values and the result beat layout. No dependencies.
`timescale 1ns / 1ps

package tsdg_pkg;

    localparam int VALUE_BITS  = 20;
    localparam int PERIOD_BITS = 26;
    localparam int TARGET_BITS = 19;
    localparam int CFG_BITS    = 26;
    localparam int CFG_IDX_BITS = 3;
    localparam int IN_BITS     = 48;
    localparam int OP_BITS     = 2;
    localparam int RESULT_BITS = 48;

    typedef enum logic [OP_BITS-1:0] {
        OP_TICK       = 2'd0,
        OP_SET_TARGET = 2'd1,
        OP_SET_POS    = 2'd2
    } op_t;

    localparam logic [CFG_IDX_BITS-1:0] CFG_X_HALF_PERIOD = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_Y_HALF_PERIOD = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_X_TARGET_MAX  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_Y_TARGET_MAX  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOME_OFFSET   = 3'd4;

    localparam logic [PERIOD_BITS-1:0] RST_HALF_PERIOD = 26'd40000000;
    localparam logic [TARGET_BITS-1:0] RST_X_TARGET_MAX = 19'd290000;
    localparam logic [TARGET_BITS-1:0] RST_Y_TARGET_MAX = 19'd305000;
    localparam logic signed [VALUE_BITS-1:0] RST_HOME_OFFSET = -20'sd1500;

    // Per-axis command strobes, valid only in the cycle of an accepted beat.
    typedef struct packed {
        logic tick;
        logic load_goal;
        logic load_pos;
    } axis_cmd_t;

    // Per-axis pin levels and sticky flags.
    typedef struct packed {
        logic end_seen;
        logic homed;
        logic dir;
        logic step;
    } axis_stat_t;

    // Result beat, last member in the lowest bits.
    typedef struct packed {
        logic [VALUE_BITS-1:0] y_now;
        logic [VALUE_BITS-1:0] x_now;
        logic y_end_seen;
        logic x_end_seen;
        logic y_homed;
        logic x_homed;
        logic y_direction;
        logic y_step;
        logic x_direction;
        logic x_step;
    } result_t;

endpackage

// ===== rtl/tsdg_axis.sv =====
// One stepper axis: tick divider, position, goal, pin levels and sticky flags.
// Depends on tsdg_pkg.
`timescale 1ns / 1ps

module tsdg_axis
    import tsdg_pkg::*;
#(
    parameter int POSITION_BITS = 20,
    parameter int DIVIDER_BITS  = 26
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  axis_cmd_t                       cmd,
    input  logic signed [VALUE_BITS-1:0]    value,
    input  logic [PERIOD_BITS-1:0]          half_period,
    input  logic [TARGET_BITS-1:0]          target_max,
    input  logic signed [VALUE_BITS-1:0]    home_offset,
    input  logic                            start_sw,
    input  logic                            end_sw,
    output axis_stat_t                      stat_next,
    output logic signed [POSITION_BITS-1:0] position_next
);

    logic [DIVIDER_BITS-1:0] count_reg, count_next, count_inc, period_d;
    logic [31:0] period_ext;
    logic signed [POSITION_BITS-1:0] position_reg, goal_reg, goal_next;
    logic signed [POSITION_BITS-1:0] value_w, clamp_w, home_w;
    logic signed [VALUE_BITS-1:0] max_s, clamp_v;
    logic signed [31:0] value32, clamp32, home32;
    axis_stat_t stat_reg;
    logic fire;

    // Only the low DIVIDER_BITS of the period count; zero acts as one.
    assign period_ext = 32'(half_period);
    assign period_d = (period_ext[DIVIDER_BITS-1:0] == '0) ? DIVIDER_BITS'(1)
                                                           : period_ext[DIVIDER_BITS-1:0];
    assign count_inc = count_reg + DIVIDER_BITS'(1);
    assign fire = !((count_inc < period_d) && (count_inc != '0));

    assign max_s   = $signed({1'b0, target_max});
    assign clamp_v = (value < max_s) ? value : max_s;
    assign value32 = 32'(value);
    assign clamp32 = 32'(clamp_v);
    assign home32  = 32'(home_offset);
    assign value_w = value32[POSITION_BITS-1:0];
    assign clamp_w = clamp32[POSITION_BITS-1:0];
    assign home_w  = home32[POSITION_BITS-1:0];

    always_comb begin
        count_next    = count_reg;
        position_next = position_reg;
        goal_next     = goal_reg;
        stat_next     = stat_reg;
        if (cmd.load_goal) begin
            goal_next = clamp_w;
        end
        if (cmd.load_pos) begin
            position_next = value_w;
        end
        if (cmd.tick) begin
            count_next = fire ? '0 : count_inc;
            if (fire) begin
                if (position_reg < goal_reg) begin
                    if (!end_sw) begin
                        stat_next.dir  = 1'b1;
                        stat_next.step = !stat_reg.step;
                        position_next  = position_reg + POSITION_BITS'(1);
                    end else begin
                        stat_next.dir      = 1'b0;
                        stat_next.end_seen = 1'b1;
                    end
                end else if (position_reg > goal_reg) begin
                    if (!start_sw) begin
                        stat_next.dir  = 1'b0;
                        stat_next.step = !stat_reg.step;
                        position_next  = position_reg - POSITION_BITS'(1);
                    end else begin
                        stat_next.dir   = 1'b1;
                        stat_next.homed = 1'b1;
                        position_next   = home_w;
                        goal_next       = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            position_reg <= '0;
            goal_reg     <= '0;
            stat_reg     <= '0;
        end else begin
            count_reg    <= count_next;
            position_reg <= position_next;
            goal_reg     <= goal_next;
            stat_reg     <= stat_next;
        end
    end

endmodule

// ===== rtl/tsdg_skid.sv =====
// Result register with one skid entry, so the input side keeps moving while
// a finished result waits. Depends on tsdg_pkg.
`timescale 1ns / 1ps

module tsdg_skid
    import tsdg_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  logic [RESULT_BITS-1:0] push_data,
    output logic                   can_push,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [RESULT_BITS-1:0] m_tdata
);

    logic main_valid_reg, skid_valid_reg;
    logic [RESULT_BITS-1:0] main_reg, skid_reg;

    assign can_push = !skid_valid_reg;
    assign m_tvalid = main_valid_reg;
    assign m_tdata  = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!main_valid_reg || m_tready) begin
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!main_valid_reg || m_tready) begin
            main_reg <= skid_valid_reg ? skid_reg : push_data;
        end else if (push) begin
            skid_reg <= push_data;
        end
    end

endmodule

// ===== rtl/two_axis_step_dir_generator.sv =====
// Top level of the two-axis step/direction generator.
// Depends on tsdg_pkg, tsdg_axis and tsdg_skid.
`timescale 1ns / 1ps

// Usage:
// Each beat on the s_ channel is one command: a clock tick of the pulse timer,
// a load of both targets (clamped to the per-axis maximum) or a load of both
// positions. The opcode travels in s_tuser. Every accepted beat produces
// exactly one result beat on the m_ channel with the pin levels, sticky homed
// and end flags and both positions as they stand after that command.
// Results are registered: an accepted beat enters the result register, or the
// skid entry while the receiver stalls. Throughput is one beat per cycle while
// s_tready is high; axis state updates in a single pass of logic per beat.
// When the receiver stalls, one more beat is taken into a skid entry, after
// which s_tready drops until the result register drains.
// Configuration goes through cfg_we/cfg_index/cfg_wdata; the user must write
// it only while no beat is in flight, which the block does not enforce, and
// writes to unknown indexes are dropped. Synchronous active-low reset clears
// both axes, the flags and the output stage, and restores register defaults.

module two_axis_step_dir_generator
    import tsdg_pkg::*;
#(
    parameter int POSITION_BITS = 20,
    parameter int DIVIDER_BITS  = 26
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_wdata,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // s_tdata: x_value[19:0], y_value[39:20], x_start_switch[40],
    // x_end_switch[41], y_start_switch[42], y_end_switch[43], zero pad [47:44]
    input  logic [IN_BITS-1:0]      s_tdata,
    // s_tuser: opcode[1:0]
    input  logic [OP_BITS-1:0]      s_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // m_tdata: x_step[0], x_direction[1], y_step[2], y_direction[3],
    // x_homed[4], y_homed[5], x_end_seen[6], y_end_seen[7],
    // x_now[27:8], y_now[47:28]
    output logic [RESULT_BITS-1:0]  m_tdata
);

    logic [PERIOD_BITS-1:0] x_half_period_reg, y_half_period_reg;
    logic [TARGET_BITS-1:0] x_target_max_reg, y_target_max_reg;
    logic signed [VALUE_BITS-1:0] home_offset_reg;

    logic accept;
    axis_cmd_t cmd;
    axis_stat_t x_stat, y_stat;
    logic signed [POSITION_BITS-1:0] x_pos_next, y_pos_next;
    logic signed [31:0] x_pos32, y_pos32;
    logic signed [VALUE_BITS-1:0] x_value, y_value;
    result_t result;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_half_period_reg <= RST_HALF_PERIOD;
            y_half_period_reg <= RST_HALF_PERIOD;
            x_target_max_reg  <= RST_X_TARGET_MAX;
            y_target_max_reg  <= RST_Y_TARGET_MAX;
            home_offset_reg   <= RST_HOME_OFFSET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_X_HALF_PERIOD: x_half_period_reg <= cfg_wdata[PERIOD_BITS-1:0];
                CFG_Y_HALF_PERIOD: y_half_period_reg <= cfg_wdata[PERIOD_BITS-1:0];
                CFG_X_TARGET_MAX:  x_target_max_reg  <= cfg_wdata[TARGET_BITS-1:0];
                CFG_Y_TARGET_MAX:  y_target_max_reg  <= cfg_wdata[TARGET_BITS-1:0];
                CFG_HOME_OFFSET:   home_offset_reg   <= cfg_wdata[VALUE_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign accept  = s_tvalid && s_tready;
    assign x_value = s_tdata[19:0];
    assign y_value = s_tdata[39:20];

    // Opcode decode; the unused code leaves all state untouched.
    always_comb begin
        cmd = '0;
        if (accept) begin
            unique case (op_t'(s_tuser))
                OP_TICK:       cmd.tick      = 1'b1;
                OP_SET_TARGET: cmd.load_goal = 1'b1;
                OP_SET_POS:    cmd.load_pos  = 1'b1;
                default: ;
            endcase
        end
    end

    tsdg_axis #(
        .POSITION_BITS (POSITION_BITS),
        .DIVIDER_BITS  (DIVIDER_BITS)
    ) u_axis_x (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .value         (x_value),
        .half_period   (x_half_period_reg),
        .target_max    (x_target_max_reg),
        .home_offset   (home_offset_reg),
        .start_sw      (s_tdata[40]),
        .end_sw        (s_tdata[41]),
        .stat_next     (x_stat),
        .position_next (x_pos_next)
    );

    tsdg_axis #(
        .POSITION_BITS (POSITION_BITS),
        .DIVIDER_BITS  (DIVIDER_BITS)
    ) u_axis_y (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .value         (y_value),
        .half_period   (y_half_period_reg),
        .target_max    (y_target_max_reg),
        .home_offset   (home_offset_reg),
        .start_sw      (s_tdata[42]),
        .end_sw        (s_tdata[43]),
        .stat_next     (y_stat),
        .position_next (y_pos_next)
    );

    // Positions are reported as their low 20 bits after sign extension.
    assign x_pos32 = 32'(x_pos_next);
    assign y_pos32 = 32'(y_pos_next);

    always_comb begin
        result.x_step      = x_stat.step;
        result.x_direction = x_stat.dir;
        result.y_step      = y_stat.step;
        result.y_direction = y_stat.dir;
        result.x_homed     = x_stat.homed;
        result.y_homed     = y_stat.homed;
        result.x_end_seen  = x_stat.end_seen;
        result.y_end_seen  = y_stat.end_seen;
        result.x_now       = x_pos32[VALUE_BITS-1:0];
        result.y_now       = y_pos32[VALUE_BITS-1:0];
    end

    tsdg_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_data (result),
        .can_push  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== rtl/tsdg_checker.sv =====
// Port-level checker for the two-axis step/direction generator, with its bind.
// Depends on tsdg_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tsdg_checker
    import tsdg_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [RESULT_BITS-1:0] m_tdata
);

    // A stalled result stays offered and unchanged.
    `ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_NEXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))

    // The output stage comes out of reset empty.
    `ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_tvalid && s_tready)

    // Input backpressure only follows a stalled result in the cycle before.
    `ASSERT_IMPL(a_ready_drop, aclk, aresetn, !s_tready, $past(m_tvalid && !m_tready))

    // While input is held off, a result is on offer.
    `ASSERT_IMPL(a_blocked_out, aclk, aresetn, !s_tready, m_tvalid)

endmodule

bind two_axis_step_dir_generator tsdg_checker u_tsdg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
